// ----- hw/rtl/brs_pkg.sv -----
// Shared types, constants and the arctangent step table of the route sampler.
package brs_pkg;

  localparam int CoordW  = 32;
  localparam int StepW   = 6;
  localparam int WgtW    = 18;
  localparam int AccW    = 52;
  localparam int HeadW   = 17;
  localparam int DeltaW  = 33;
  localparam int CordW   = 36;
  localparam int AngW    = 22;
  localparam int CordIt  = 19;

  localparam logic [StepW-1:0] STEPS_RESET = 6'd10;
  localparam logic [StepW-1:0] STEPS_MIN   = 6'd2;

  localparam logic signed [HeadW-1:0] HD_EAST  = 17'sd0;
  localparam logic signed [HeadW-1:0] HD_WEST  = 17'sd32768;
  localparam logic signed [HeadW-1:0] HD_NORTH = 17'sd16384;
  localparam logic signed [HeadW-1:0] HD_SOUTH = -17'sd16384;

  localparam logic signed [AngW-1:0] ANG_HALF = 22'sd524288;

  typedef logic signed [CoordW-1:0] coord_t;

  // atan(2^-i) in 2^-20 turn
  function automatic logic signed [AngW-1:0] atan_step(input logic [4:0] i);
    logic signed [AngW-1:0] v;
    begin
      case (i)
        5'd0:    v = 22'sd131072;
        5'd1:    v = 22'sd77376;
        5'd2:    v = 22'sd40884;
        5'd3:    v = 22'sd20753;
        5'd4:    v = 22'sd10417;
        5'd5:    v = 22'sd5213;
        5'd6:    v = 22'sd2607;
        5'd7:    v = 22'sd1304;
        5'd8:    v = 22'sd652;
        5'd9:    v = 22'sd326;
        5'd10:   v = 22'sd163;
        5'd11:   v = 22'sd81;
        5'd12:   v = 22'sd41;
        5'd13:   v = 22'sd20;
        5'd14:   v = 22'sd10;
        5'd15:   v = 22'sd5;
        5'd16:   v = 22'sd3;
        5'd17:   v = 22'sd1;
        5'd18:   v = 22'sd1;
        default: v = 22'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- hw/rtl/brs_div.sv -----
// Iterative divider: rounds |num| / den to nearest, restores sign, saturates to 32 bits.
module brs_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [brs_pkg::AccW-1:0]    num,
  input  logic        [brs_pkg::WgtW-1:0]    den,
  output logic                               done,
  output brs_pkg::coord_t                    quo
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dst_t;

  dst_t         st_r;
  logic [18:0]  rem_r;
  logic [31:0]  q_r;
  logic [4:0]   cnt_r;
  logic         neg_r;

  logic [brs_pkg::AccW-1:0] mag;
  logic [18:0]              trial;
  logic                     fits;
  logic signed [32:0]       sres;

  assign mag   = (num < 0 ? brs_pkg::AccW'(-num) : brs_pkg::AccW'(num))
               + brs_pkg::AccW'(den >> 1);
  assign trial = {rem_r[17:0], q_r[31]};
  assign fits  = trial >= {1'b0, den};
  assign sres  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        D_IDLE: begin
          if (start) begin
            rem_r <= {1'b0, mag[49:32]};
            q_r   <= mag[31:0];
            neg_r <= num < 0;
            cnt_r <= '0;
            st_r  <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= fits ? trial - {1'b0, den} : trial;
          q_r   <= {q_r[30:0], fits};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) st_r <= D_FIN;
        end
        D_FIN: begin
          if (sres > 33'sd2147483647)       quo <= 32'sh7FFFFFFF;
          else if (sres < -33'sd2147483648) quo <= 32'sh80000000;
          else                              quo <= sres[31:0];
          done <= 1'b1;
          st_r <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/brs_cordic.sv -----
// Iterative CORDIC vectoring: heading of a move in 1/65536 turn.
module brs_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [brs_pkg::DeltaW-1:0]   dx,
  input  logic signed [brs_pkg::DeltaW-1:0]   dy,
  output logic                                done,
  output logic signed [brs_pkg::HeadW-1:0]    heading
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cst_t;

  cst_t                               st_r;
  logic signed [brs_pkg::CordW-1:0]   x_r, y_r;
  logic signed [brs_pkg::AngW-1:0]    z_r;
  logic [4:0]                         i_r;

  logic signed [brs_pkg::CordW-1:0]   xs, ys;
  logic signed [brs_pkg::AngW-1:0]    ang, zr;
  logic signed [17:0]                 hraw, hwrap;

  assign xs  = x_r >>> i_r;
  assign ys  = y_r >>> i_r;
  assign ang = brs_pkg::atan_step(i_r);
  assign zr  = z_r + 22'sd8;
  assign hraw = zr[21:4];

  always_comb begin
    if (hraw > 18'sd32768)        hwrap = hraw - 18'sd65536;
    else if (hraw <= -18'sd32768) hwrap = hraw + 18'sd65536;
    else                          hwrap = hraw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        C_IDLE: begin
          if (start) begin
            if (dy == 0) begin
              heading <= dx > 0 ? brs_pkg::HD_EAST : brs_pkg::HD_WEST;
              done    <= 1'b1;
            end else if (dx == 0) begin
              heading <= dy > 0 ? brs_pkg::HD_NORTH : brs_pkg::HD_SOUTH;
              done    <= 1'b1;
            end else begin
              if (dx < 0) begin
                x_r <= -brs_pkg::CordW'(dx);
                y_r <= -brs_pkg::CordW'(dy);
                z_r <= brs_pkg::ANG_HALF;
              end else begin
                x_r <= brs_pkg::CordW'(dx);
                y_r <= brs_pkg::CordW'(dy);
                z_r <= '0;
              end
              i_r  <= '0;
              st_r <= C_RUN;
            end
          end
        end
        C_RUN: begin
          if (y_r >= 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + ang;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - ang;
          end
          i_r <= i_r + 5'd1;
          if (i_r == 5'(brs_pkg::CordIt - 1)) st_r <= C_FIN;
        end
        C_FIN: begin
          heading <= hwrap[16:0];
          done    <= 1'b1;
          st_r    <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/bezier_route_sampler.sv -----
// Top level: cubic Bezier edge sampler with heading, one shared multiplier under a sequencer.
//
//  channel | dir | words                          | handshake
//  in_     | in  | one route edge                 | tvalid/tready
//  out_    | out | one curve point, tlast on last | tvalid/tready
//  cfg_    | in  | steps_per_edge                 | cfg_wen, no wait
//
// One edge gives n+1 words; each is formed by 6 weight products, per axis 4
// multiply-accumulates on the shared multiplier and a pass through the bit-serial divider,
// a heading decision, the CORDIC where needed, and the hand-off, which waits on output stall.
// Each edge is first accepted and then forms n^3 on the shared multiplier.
// in_tready is high only when idle.
// rst_n clears control, the previous point and steps_per_edge (to 10).
module bezier_route_sampler #(
  parameter int MAX_STEPS = 63
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, edge_tag
  input  logic [271:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_x, point_y, heading, point_edge_tag, 7 zero bits
  output logic [103:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_wen,
  input  logic [5:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_NCUBE, S_WGT, S_MAC, S_DIV, S_HEAD, S_CORD, S_OUT
  } state_t;

  localparam logic [5:0] StepsMax = 6'(MAX_STEPS);

  state_t                              state_r;
  logic [brs_pkg::StepW-1:0]           steps_r, n_r, s_r;
  logic [2:0]                          cnt_r;
  logic                                ax_r;
  brs_pkg::coord_t                     pt_r [8];
  logic [15:0]                         tag_r;
  logic [11:0]                         a2_r, s2_r;
  logic [brs_pkg::WgtW-1:0]            w_r [4];
  logic [brs_pkg::WgtW-1:0]            n3_r;
  logic signed [brs_pkg::AccW-1:0]     acc_r;
  brs_pkg::coord_t                     bx_r, by_r, prev_x_r, prev_y_r;
  logic signed [brs_pkg::HeadW-1:0]    hd_r, prev_hd_r;
  logic                                have_r;
  logic                                div_start_r, cord_start_r;

  logic [brs_pkg::StepW-1:0]           a_cur, steps_cl;
  logic signed [18:0]                  mul_a;
  logic signed [31:0]                  mul_b;
  logic signed [50:0]                  prod;
  logic [brs_pkg::WgtW-1:0]            prod_w, prod_w3;
  logic signed [brs_pkg::AccW-1:0]     acc_nxt;
  logic                                div_done, cord_done;
  brs_pkg::coord_t                     div_q;
  logic signed [brs_pkg::HeadW-1:0]    cord_hd;
  logic signed [brs_pkg::DeltaW-1:0]   dx, dy;

  assign a_cur    = n_r - s_r;
  assign steps_cl = steps_r < brs_pkg::STEPS_MIN ? brs_pkg::STEPS_MIN :
                    steps_r > StepsMax ? StepsMax : steps_r;

  always_comb begin
    mul_a = 19'sd0;
    mul_b = 32'sd0;
    if (state_r == S_MAC) begin
      mul_a = $signed({1'b0, w_r[cnt_r[1:0]]});
      mul_b = pt_r[{cnt_r[1:0], ax_r}];
    end else if (state_r == S_NCUBE) begin
      mul_a = $signed(19'(cnt_r[0] ? a2_r : 12'(n_r)));
      mul_b = $signed(32'(n_r));
    end else begin
      case (cnt_r)
        3'd0:    begin mul_a = $signed(19'(a_cur)); mul_b = $signed(32'(a_cur)); end
        3'd1:    begin mul_a = $signed(19'(a2_r));  mul_b = $signed(32'(a_cur)); end
        3'd2:    begin mul_a = $signed(19'(s_r));   mul_b = $signed(32'(s_r));   end
        3'd3:    begin mul_a = $signed(19'(s2_r));  mul_b = $signed(32'(s_r));   end
        3'd4:    begin mul_a = $signed(19'(a2_r));  mul_b = $signed(32'(s_r));   end
        default: begin mul_a = $signed(19'(s2_r));  mul_b = $signed(32'(a_cur)); end
      endcase
    end
  end

  assign prod    = mul_a * mul_b;
  assign prod_w  = prod[brs_pkg::WgtW-1:0];
  assign prod_w3 = prod_w + {prod_w[brs_pkg::WgtW-2:0], 1'b0};
  assign acc_nxt = (cnt_r == 3'd0 ? '0 : acc_r) + {prod[50], prod};
  assign dx      = $signed({bx_r[31], bx_r}) - $signed({prev_x_r[31], prev_x_r});
  assign dy      = $signed({by_r[31], by_r}) - $signed({prev_y_r[31], prev_y_r});

  brs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (acc_r),
    .den   (n3_r),
    .done  (div_done),
    .quo   (div_q)
  );

  brs_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cord_start_r),
    .dx      (dx),
    .dy      (dy),
    .done    (cord_done),
    .heading (cord_hd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      steps_r      <= brs_pkg::STEPS_RESET;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_hd_r    <= '0;
      have_r       <= 1'b0;
      div_start_r  <= 1'b0;
      cord_start_r <= 1'b0;
    end else begin
      div_start_r  <= 1'b0;
      cord_start_r <= 1'b0;
      if (cfg_wen) steps_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            for (int k = 0; k < 8; k++) pt_r[k] <= in_tdata[32*k +: 32];
            tag_r   <= in_tdata[271:256];
            n_r     <= steps_cl;
            s_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_NCUBE;
          end
        end
        S_NCUBE: begin
          if (cnt_r[0]) begin
            n3_r    <= prod_w;
            cnt_r   <= '0;
            state_r <= S_WGT;
          end else begin
            a2_r  <= prod[11:0];
            cnt_r <= 3'd1;
          end
        end
        S_WGT: begin
          case (cnt_r)
            3'd0:    a2_r   <= prod[11:0];
            3'd1:    w_r[0] <= prod_w;
            3'd2:    s2_r   <= prod[11:0];
            3'd3:    w_r[3] <= prod_w;
            3'd4:    w_r[1] <= prod_w3;
            default: w_r[2] <= prod_w3;
          endcase
          if (cnt_r == 3'd5) begin
            cnt_r   <= '0;
            ax_r    <= 1'b0;
            state_r <= S_MAC;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_MAC: begin
          acc_r <= acc_nxt;
          if (cnt_r == 3'd3) begin
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cnt_r <= '0;
            if (!ax_r) begin
              bx_r    <= div_q;
              ax_r    <= 1'b1;
              state_r <= S_MAC;
            end else begin
              by_r    <= div_q;
              state_r <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          if (!have_r) begin
            hd_r    <= '0;
            state_r <= S_OUT;
          end else if (dx == 0 && dy == 0) begin
            hd_r    <= prev_hd_r;
            state_r <= S_OUT;
          end else begin
            cord_start_r <= 1'b1;
            state_r      <= S_CORD;
          end
        end
        S_CORD: begin
          if (cord_done) begin
            hd_r    <= cord_hd;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            prev_x_r  <= bx_r;
            prev_y_r  <= by_r;
            prev_hd_r <= hd_r;
            have_r    <= 1'b1;
            cnt_r     <= '0;
            if (s_r == n_r) begin
              state_r <= S_IDLE;
            end else begin
              s_r     <= s_r + 6'd1;
              state_r <= S_WGT;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = state_r == S_OUT;
  assign out_tlast  = s_r == n_r;
  assign out_tdata  = {7'd0, tag_r, hd_r, by_r, bx_r};

endmodule

// ----- tb/sv/bezier_route_sampler_tb.sv -----
// Testbench for bezier_route_sampler: directed and random route edges checked against a predictor.
`timescale 1ns / 100ps

module bezier_route_sampler_tb;

  localparam int  LIMIT_CYCLES = 20000000;
  localparam int  DRAIN_CYCLES = 40;

  typedef struct {
    brs_pkg::coord_t         sx, sy, c1x, c1y, c2x, c2y, ex, ey;
    logic [15:0]             tag;
  } route_edge_t;

  typedef struct {
    brs_pkg::coord_t                  px, py;
    logic signed [brs_pkg::HeadW-1:0] hd;
    logic [15:0]                      tag;
    logic                             last;
  } curve_point_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [271:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         out_tlast;
  logic         cfg_wen = 1'b0;
  logic [5:0]   cfg_wdata = '0;

  curve_point_t pending_points[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           step_setting = 10;
  longint       last_x = 0, last_y = 0;
  logic signed [brs_pkg::HeadW-1:0] last_hd = '0;
  bit           seen_point = 0;
  bit           ready_free = 1;
  longint       atan_tab[19] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304, 652,
                                 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

  bezier_route_sampler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint curve_coord(longint p0, longint p1, longint p2, longint p3,
                                         longint n, longint s);
    longint a, n3, num, mag, q;
    a = n - s;
    n3 = n * n * n;
    num = a * a * a * p0 + 3 * a * a * s * p1 + 3 * a * s * s * p2 + s * s * s * p3;
    mag = num < 0 ? -num : num;
    q = (mag + n3 / 2) / n3;
    if (num < 0) q = -q;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic logic signed [brs_pkg::HeadW-1:0] move_heading(longint dx, longint dy);
    longint x, y, z, xs, ys, h;
    if (dy == 0) return dx > 0 ? brs_pkg::HD_EAST : brs_pkg::HD_WEST;
    if (dx == 0) return dy > 0 ? brs_pkg::HD_NORTH : brs_pkg::HD_SOUTH;
    if (dx < 0) begin
      x = -dx; y = -dy; z = 524288;
    end else begin
      x = dx; y = dy; z = 0;
    end
    for (int i = 0; i < brs_pkg::CordIt; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    h = (z + 8) >>> 4;
    if (h > 32768) h -= 65536;
    if (h <= -32768) h += 65536;
    return h[brs_pkg::HeadW-1:0];
  endfunction

  task automatic predict_edge_points(route_edge_t e);
    longint       n, bx, by;
    curve_point_t p;
    n = step_setting < 2 ? 2 : (step_setting > 63 ? 63 : step_setting);
    for (longint s = 0; s <= n; s++) begin
      bx = curve_coord(e.sx, e.c1x, e.c2x, e.ex, n, s);
      by = curve_coord(e.sy, e.c1y, e.c2y, e.ey, n, s);
      p.hd = '0;
      if (seen_point) p.hd = (bx != last_x || by != last_y) ?
                             move_heading(bx - last_x, by - last_y) : last_hd;
      last_x = bx; last_y = by; last_hd = p.hd; seen_point = 1;
      p.px = bx[31:0]; p.py = by[31:0]; p.tag = e.tag; p.last = (s == n);
      pending_points.insert(pending_points.size(), p);
    end
  endtask

  task automatic send_edge(route_edge_t e);
    @(negedge clk);
    in_tdata  = {e.tag, e.ey, e.ex, e.c2y, e.c2x, e.c1y, e.c1x, e.sy, e.sx};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_edge_points(e);
  endtask

  task automatic sender_gap(int cycles);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_points();
    sender_gap(0);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_steps(int v);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_wdata = v[5:0];
    @(negedge clk);
    cfg_wen = 1'b0;
    step_setting = v;
  endtask

  function automatic route_edge_t line_edge(longint x0, longint y0, longint x1, longint y1,
                                            int tag);
    route_edge_t e;
    e.sx = brs_pkg::coord_t'(x0); e.sy = brs_pkg::coord_t'(y0);
    e.c1x = brs_pkg::coord_t'(x0); e.c1y = brs_pkg::coord_t'(y0);
    e.c2x = brs_pkg::coord_t'(x1); e.c2y = brs_pkg::coord_t'(y1);
    e.ex = brs_pkg::coord_t'(x1); e.ey = brs_pkg::coord_t'(y1); e.tag = 16'(tag);
    return e;
  endfunction

  function automatic brs_pkg::coord_t rand_coord(int kind, brs_pkg::coord_t base);
    case (kind)
      0: return $urandom;
      1: return base + $signed($urandom_range(0, 2000000)) - 1000000;
      2: return base;
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic route_edge_t random_edge(brs_pkg::coord_t x0, brs_pkg::coord_t y0);
    route_edge_t e;
    int          kind;
    kind = $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 3);
    e.sx  = $urandom_range(0, 4) != 0 ? x0 : rand_coord(kind, x0);
    e.sy  = $urandom_range(0, 4) != 0 ? y0 : rand_coord(kind, y0);
    e.ex  = rand_coord(kind == 2 ? 1 : kind, e.sx);
    e.ey  = rand_coord(kind == 2 ? 1 : kind, e.sy);
    e.c1x = $urandom_range(0, 3) == 0 ? e.sx : rand_coord(kind, e.sx);
    e.c1y = $urandom_range(0, 3) == 0 ? e.sy : rand_coord(kind, e.sy);
    e.c2x = $urandom_range(0, 3) == 0 ? e.ex : rand_coord(kind, e.ex);
    e.c2y = $urandom_range(0, 3) == 0 ? e.ey : rand_coord(kind, e.ey);
    e.tag = 16'($urandom);
    return e;
  endfunction

  task automatic test_directed_edges();
    route_edge_t e;
    send_edge(line_edge(0, 0, 0, 0, 16'h0000));
    send_edge(line_edge(0, 0, 32'sh000a0000, 0, 16'hffff));
    send_edge(line_edge(32'sh000a0000, 0, -32'sh000a0000, 0, 16'h1234));
    send_edge(line_edge(-32'sh000a0000, 0, -32'sh000a0000, 32'sh00050000, 16'h00ff));
    send_edge(line_edge(-32'sh000a0000, 32'sh00050000, -32'sh000a0000, -32'sh00050000, 16'hff00));
    send_edge(line_edge(-32'sh000a0000, -32'sh00050000, 32'sh00030007, 32'sh00110003, 16'h5a5a));
    send_edge(line_edge(32'sh00030007, 32'sh00110003, -32'sh00070001, -32'sh00020009, 16'ha5a5));
    send_edge(line_edge(-32'sh00070001, -32'sh00020009, -32'sh00070001, -32'sh00020009, 16'h0001));
    send_edge(line_edge(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 16'h8000));
    send_edge(line_edge(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 16'h7fff));
    e.sx = 32'h80000000; e.sy = 32'h7fffffff; e.c1x = 32'h7fffffff; e.c1y = 32'h80000000;
    e.c2x = 32'h7fffffff; e.c2y = 32'h80000000; e.ex = 32'h80000000; e.ey = 32'h7fffffff;
    e.tag = 16'hffff;
    send_edge(e);
    e.sx = 0; e.sy = 0; e.c1x = 32'sh00100000; e.c1y = 32'sh00200000;
    e.c2x = -32'sh00300000; e.c2y = 32'sh00050000; e.ex = 1; e.ey = -1; e.tag = 16'hbeef;
    send_edge(e);
    drain_points();
  endtask

  task automatic test_step_extremes();
    int settings[5] = '{0, 1, 2, 63, 3};
    foreach (settings[i]) begin
      write_steps(settings[i]);
      send_edge(random_edge(brs_pkg::coord_t'(last_x), brs_pkg::coord_t'(last_y)));
      send_edge(line_edge(32'sh00010000, 32'sh00010000, -32'sh00020000, 32'sh00030000, i));
      drain_points();
    end
  endtask

  task automatic test_random_edges(int total);
    int sent = 0;
    int burst;
    while (sent < total) begin
      if (sent % 80 == 0) begin
        drain_points();
        write_steps($urandom_range(0, 19) == 0 ? $urandom_range(0, 63) : $urandom_range(2, 6));
        ready_free = $urandom_range(0, 2) == 0;
      end
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        send_edge(random_edge(brs_pkg::coord_t'(last_x), brs_pkg::coord_t'(last_y)));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(0, 30));
    end
    drain_points();
  endtask

  always @(negedge clk) begin
    if (ready_free) out_tready <= 1'b1;
    else out_tready <= ((cycle_count % 13) < 9) ? $urandom_range(0, 3) != 0 : 1'b0;
  end

  always @(posedge clk) begin
    curve_point_t exp_pt;
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        $error("curve point with none expected: %h", out_tdata);
        fail_count++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (out_tdata[31:0] !== exp_pt.px) begin
          $error("point_x expected %h got %h", exp_pt.px, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[63:32] !== exp_pt.py) begin
          $error("point_y expected %h got %h", exp_pt.py, out_tdata[63:32]);
          fail_count++;
        end
        if (out_tdata[80:64] !== exp_pt.hd) begin
          $error("heading expected %0d got %0d", exp_pt.hd, $signed(out_tdata[80:64]));
          fail_count++;
        end
        if (out_tdata[96:81] !== exp_pt.tag) begin
          $error("point_edge_tag expected %h got %h", exp_pt.tag, out_tdata[96:81]);
          fail_count++;
        end
        if (out_tlast !== exp_pt.last) begin
          $error("last_of_edge expected %b got %b", exp_pt.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_edges();
    ready_free = 0;
    test_step_extremes();
    test_random_edges(400);
    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
